/* sv/xdm_pkg.sv */
// shared types and constants for the x-drive omni wheel mixer
`timescale 1ns / 1ps
`default_nettype none

package xdm_pkg;

  // wheel speed width
  localparam int SPEED_BITS = 16;
  localparam int HEAD_BITS  = 13;
  localparam int RATE_BITS  = 16;
  localparam int ANG_BITS   = 13;
  localparam int QX_BITS    = 11;

  // angle constants in sixteenths of a degree
  localparam logic [ANG_BITS-1:0] QUARTER       = 13'd1440;
  localparam logic [ANG_BITS-1:0] HALF_TURN     = 13'd2880;
  localparam logic [ANG_BITS-1:0] THREE_QUARTER = 13'd4320;
  localparam logic [ANG_BITS:0]   FULL_TURN     = 14'd5760;
  localparam logic [ANG_BITS:0]   DIAG_OFFSET   = 14'd720;

  // turn rate limits, q2.14
  localparam logic signed [RATE_BITS-1:0] RATE_ONE     = 16'sd16384;
  localparam logic signed [RATE_BITS-1:0] RATE_NEG_ONE = -16'sd16384;

  // symmetric speed range
  localparam logic signed [SPEED_BITS-1:0] SPEED_MIN =
    {1'b1, {(SPEED_BITS-1){1'b0}}};
  localparam logic signed [SPEED_BITS-1:0] SPEED_NEG_MAX =
    {1'b1, {(SPEED_BITS-2){1'b0}}, 1'b1};

  // angle to q15 scaling: t = (1024*x + 22) / 45 via reciprocal
  localparam int NUM_BITS    = 21;
  localparam int RECIP_BITS  = 22;
  localparam int RECIP_SHIFT = 27;
  localparam int T_BITS      = 16;
  localparam logic [RECIP_BITS-1:0] RECIP   = 22'd2982616;
  localparam logic [NUM_BITS-1:0]   NUM_RND = 21'd22;
  localparam logic [6:0]            DIV_K   = 7'd45;

  // q30 odd polynomial coefficients
  localparam logic signed [31:0] C1 = 32'sd1686629713;
  localparam logic signed [30:0] C3 = -31'sd693598243;
  localparam logic signed [27:0] C5 = 28'sd85557789;
  localparam logic signed [23:0] C7 = -24'sd4847435;

  // stages inside one quarter sine unit
  localparam int SIN_LAT = 7;

  typedef enum logic {
    OP_MOVE   = 1'b0,
    OP_ROTATE = 1'b1
  } op_e;

  // per command data that rides beside the sine units
  typedef struct packed {
    op_e                           op;
    logic signed [SPEED_BITS-1:0]  speed;
    logic                          pos;
    logic signed [RATE_BITS-1:0]   m;
    logic                          fwd1;
    logic                          fwd2;
    logic [1:0]                    quad;
  } side_t;

endpackage

`default_nettype wire

/* sv/xdm_if.sv */
// valid/ready channel interfaces for drive commands and wheel speeds
`timescale 1ns / 1ps
`default_nettype none

interface xdm_cmd_if;
  import xdm_pkg::*;

  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic signed [SPEED_BITS-1:0]  drive_speed;
  logic [HEAD_BITS-1:0]          heading;
  logic signed [RATE_BITS-1:0]   turn_rate;

  modport source (output valid, opcode, drive_speed, heading, turn_rate, input ready);
  modport sink   (input valid, opcode, drive_speed, heading, turn_rate, output ready);
endinterface

interface xdm_whl_if;
  import xdm_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SPEED_BITS-1:0]  front_left_speed;
  logic signed [SPEED_BITS-1:0]  front_right_speed;
  logic signed [SPEED_BITS-1:0]  back_left_speed;
  logic signed [SPEED_BITS-1:0]  back_right_speed;

  modport source (output valid, front_left_speed, front_right_speed, back_left_speed,
                  back_right_speed, input ready);
  modport sink   (input valid, front_left_speed, front_right_speed, back_left_speed,
                  back_right_speed, output ready);
endinterface

`default_nettype wire

/* sv/xdm_angle_prep.sv */
// front end: heading wrap, input saturation, quadrant split, rate factor
`timescale 1ns / 1ps
`default_nettype none

module xdm_angle_prep (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  en_i,
  input  wire logic                                  valid_i,
  input  wire xdm_pkg::op_e                          op_i,
  input  wire logic signed [xdm_pkg::SPEED_BITS-1:0] speed_i,
  input  wire logic [xdm_pkg::HEAD_BITS-1:0]         heading_i,
  input  wire logic signed [xdm_pkg::RATE_BITS-1:0]  rate_i,
  output logic                                       valid_o,
  output logic [xdm_pkg::NUM_BITS-1:0]               num_a_o,
  output logic [xdm_pkg::NUM_BITS-1:0]               num_b_o,
  output xdm_pkg::side_t                             side_o
);
  import xdm_pkg::*;

  logic                          v1_q, v2_q;
  op_e                           op1_q;
  logic [ANG_BITS-1:0]           a1_q, a1_d;
  logic signed [SPEED_BITS-1:0]  spd1_q, spd1_d;
  logic signed [RATE_BITS-1:0]   rate1_q, rate1_d;
  logic [ANG_BITS:0]             hsum;

  logic [1:0]                    quad;
  logic [ANG_BITS-1:0]           rem_a;
  logic [QX_BITS-1:0]            xa, xb;
  logic                          pos;
  logic [RATE_BITS-1:0]          absr;
  logic signed [RATE_BITS:0]     m_wide;
  side_t                         side_d, side_q;
  logic [NUM_BITS-1:0]           num_a_d, num_b_d, num_a_q, num_b_q;

  // stage 1: wrap heading + 45 deg, clamp speed and rate
  always_comb begin
    hsum = {1'b0, heading_i} + DIAG_OFFSET;
    if (hsum >= FULL_TURN) begin
      a1_d = ANG_BITS'(hsum - FULL_TURN);
    end else begin
      a1_d = hsum[ANG_BITS-1:0];
    end
    spd1_d = (speed_i == SPEED_MIN) ? SPEED_NEG_MAX : speed_i;
    if (rate_i > RATE_ONE) begin
      rate1_d = RATE_ONE;
    end else if (rate_i < RATE_NEG_ONE) begin
      rate1_d = RATE_NEG_ONE;
    end else begin
      rate1_d = rate_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op1_q   <= op_i;
      a1_q    <= a1_d;
      spd1_q  <= spd1_d;
      rate1_q <= rate1_d;
    end
  end

  // stage 2: quadrant, offsets into the quarter wave, wheel factor
  always_comb begin
    if (a1_q < QUARTER) begin
      quad  = 2'd0;
      rem_a = a1_q;
    end else if (a1_q < HALF_TURN) begin
      quad  = 2'd1;
      rem_a = a1_q - QUARTER;
    end else if (a1_q < THREE_QUARTER) begin
      quad  = 2'd2;
      rem_a = a1_q - HALF_TURN;
    end else begin
      quad  = 2'd3;
      rem_a = a1_q - THREE_QUARTER;
    end
    xa      = rem_a[QX_BITS-1:0];
    xb      = QUARTER[QX_BITS-1:0] - xa;
    num_a_d = {xa, 10'b0} + NUM_RND;
    num_b_d = {xb, 10'b0} + NUM_RND;

    pos    = ~rate1_q[RATE_BITS-1];
    absr   = pos ? rate1_q : -rate1_q;
    m_wide = $signed({2'b0, RATE_ONE[RATE_BITS-2:0]})
           - $signed({1'b0, absr[RATE_BITS-2:0], 1'b0});

    side_d.op    = op1_q;
    side_d.speed = spd1_q;
    side_d.pos   = pos;
    side_d.m     = m_wide[RATE_BITS-1:0];
    side_d.fwd1  = (a1_q <= HALF_TURN);
    side_d.fwd2  = !((a1_q >= QUARTER) && (a1_q <= THREE_QUARTER));
    side_d.quad  = quad;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_a_q <= num_a_d;
      num_b_q <= num_b_d;
      side_q  <= side_d;
    end
  end

  assign valid_o = v2_q;
  assign num_a_o = num_a_q;
  assign num_b_o = num_b_q;
  assign side_o  = side_q;

endmodule

`default_nettype wire

/* sv/xdm_sin_quarter.sv */
// pipelined quarter-wave sine: q15 scaling then horner polynomial
`timescale 1ns / 1ps
`default_nettype none

module xdm_sin_quarter (
  input  wire logic                            clk_i,
  input  wire logic                            en_i,
  input  wire logic [xdm_pkg::NUM_BITS-1:0]    num_i,
  output logic [xdm_pkg::T_BITS-1:0]           sin_o
);
  import xdm_pkg::*;

  logic [NUM_BITS+RECIP_BITS-1:0] prod1;
  logic [NUM_BITS-1:0]            num1_q;
  logic [T_BITS-1:0]              qe1_q;
  logic [NUM_BITS-1:0]            rem2;
  logic [T_BITS-1:0]              t2_d, t2_q, t3_q, t4_q, t5_q, t6_q;
  logic [2*T_BITS-1:0]            sq3;
  logic [T_BITS-1:0]              z3_q, z4_q, z5_q;
  logic signed [40:0]             prod4, sh4;
  logic signed [27:0]             p5_q;
  logic signed [44:0]             prod5, sh5;
  logic signed [30:0]             p3_q;
  logic signed [47:0]             prod6, sh6;
  logic signed [31:0]             p1_q;
  logic signed [48:0]             prod7, sum7;
  logic [T_BITS-1:0]              sin_q;

  // stage 1: quotient estimate by reciprocal multiply
  assign prod1 = num_i * RECIP;

  // stage 2: one-step correction of the estimate
  always_comb begin
    rem2 = num1_q - NUM_BITS'(qe1_q) * NUM_BITS'(DIV_K);
    t2_d = (rem2 >= NUM_BITS'(DIV_K)) ? qe1_q + 1'b1 : qe1_q;
  end

  // stage 3: z = t^2 in q15
  assign sq3 = t2_q * t2_q;

  // stages 4 to 6: horner steps on z
  assign prod4 = C7 * $signed({1'b0, z3_q});
  assign sh4   = prod4 >>> 15;
  assign prod5 = p5_q * $signed({1'b0, z4_q});
  assign sh5   = prod5 >>> 15;
  assign prod6 = p3_q * $signed({1'b0, z5_q});
  assign sh6   = prod6 >>> 15;

  // stage 7: final multiply by t with rounding
  assign prod7 = p1_q * $signed({1'b0, t6_q});
  assign sum7  = prod7 + $signed({19'b0, 1'b1, 29'b0});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qe1_q  <= prod1[RECIP_SHIFT +: T_BITS];
      num1_q <= num_i;
      t2_q   <= t2_d;
      z3_q   <= sq3[15 +: T_BITS];
      t3_q   <= t2_q;
      p5_q   <= C5 + $signed(sh4[27:0]);
      z4_q   <= z3_q;
      t4_q   <= t3_q;
      p3_q   <= C3 + $signed(sh5[30:0]);
      z5_q   <= z4_q;
      t5_q   <= t4_q;
      p1_q   <= C1 + $signed(sh6[31:0]);
      t6_q   <= t5_q;
      sin_q  <= sum7[30 +: T_BITS];
    end
  end

  assign sin_o = sin_q;

endmodule

`default_nettype wire

/* sv/xdm_wheel_mix.sv */
// back end: signed sine/cosine, diagonal speeds, reduced wheels, wheel routing
`timescale 1ns / 1ps
`default_nettype none

module xdm_wheel_mix (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  en_i,
  input  wire logic                                  valid_i,
  input  wire xdm_pkg::side_t                        side_i,
  input  wire logic [xdm_pkg::T_BITS-1:0]            sa_i,
  input  wire logic [xdm_pkg::T_BITS-1:0]            sb_i,
  output logic                                       valid_o,
  output logic signed [xdm_pkg::SPEED_BITS-1:0]      fl_o,
  output logic signed [xdm_pkg::SPEED_BITS-1:0]      fr_o,
  output logic signed [xdm_pkg::SPEED_BITS-1:0]      bl_o,
  output logic signed [xdm_pkg::SPEED_BITS-1:0]      br_o
);
  import xdm_pkg::*;

  logic [T_BITS-1:0]               s_mag, c_mag;
  logic signed [T_BITS:0]          s_val, c_val;
  logic signed [SPEED_BITS+16:0]   prod_s, prod_c, sum_s, sum_c;
  logic                            v1_q, v2_q, v3_q;
  side_t                           side1_q, side2_q;
  logic signed [SPEED_BITS-1:0]    d1_q, d2_q, d1_r_q, d2_r_q;
  logic signed [SPEED_BITS-1:0]    d1_s2_q, d2_s2_q;
  logic signed [SPEED_BITS+15:0]   prod_1, prod_2, sum_1, sum_2;
  logic signed [SPEED_BITS-1:0]    fl_d, fr_d, bl_d, br_d;
  logic signed [SPEED_BITS-1:0]    fl_q, fr_q, bl_q, br_q;

  // stage 1: pick sine and cosine by quadrant, scale the speed
  always_comb begin
    if (side_i.quad[0]) begin
      s_mag = sb_i;
      c_mag = sa_i;
    end else begin
      s_mag = sa_i;
      c_mag = sb_i;
    end
    s_val  = side_i.quad[1] ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
    c_val  = (side_i.quad[1] ^ side_i.quad[0]) ? -$signed({1'b0, c_mag})
                                                : $signed({1'b0, c_mag});
    prod_s = side_i.speed * s_val;
    prod_c = side_i.speed * c_val;
    sum_s  = prod_s + $signed({{(SPEED_BITS+2){1'b0}}, 1'b1, 14'b0});
    sum_c  = prod_c + $signed({{(SPEED_BITS+2){1'b0}}, 1'b1, 14'b0});
  end

  // stage 2: reduced diagonal speeds
  always_comb begin
    prod_1 = d1_q * side1_q.m;
    prod_2 = d2_q * side1_q.m;
    sum_1  = prod_1 + $signed({{(SPEED_BITS+2){1'b0}}, 1'b1, 13'b0});
    sum_2  = prod_2 + $signed({{(SPEED_BITS+2){1'b0}}, 1'b1, 13'b0});
  end

  // stage 3: route full and reduced speeds to the wheels
  always_comb begin
    if (side2_q.op == OP_ROTATE) begin
      fl_d = side2_q.speed;
      fr_d = side2_q.speed;
      bl_d = side2_q.speed;
      br_d = side2_q.speed;
    end else begin
      if (side2_q.fwd1 == side2_q.pos) begin
        fl_d = d1_s2_q;
        br_d = d1_r_q;
      end else begin
        fl_d = d1_r_q;
        br_d = d1_s2_q;
      end
      if (side2_q.fwd2 == side2_q.pos) begin
        fr_d = d2_r_q;
        bl_d = d2_s2_q;
      end else begin
        fr_d = d2_s2_q;
        bl_d = d2_r_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side1_q <= side_i;
      d1_q    <= sum_s[15 +: SPEED_BITS];
      d2_q    <= sum_c[15 +: SPEED_BITS];
      side2_q <= side1_q;
      d1_s2_q <= d1_q;
      d2_s2_q <= d2_q;
      d1_r_q  <= sum_1[14 +: SPEED_BITS];
      d2_r_q  <= sum_2[14 +: SPEED_BITS];
      fl_q    <= fl_d;
      fr_q    <= fr_d;
      bl_q    <= bl_d;
      br_q    <= br_d;
    end
  end

  assign valid_o = v3_q;
  assign fl_o    = fl_q;
  assign fr_o    = fr_q;
  assign bl_o    = bl_q;
  assign br_o    = br_q;

endmodule

`default_nettype wire

/* sv/x_drive_omni_wheel_mixer_unit.sv */
// top level: four-wheel x-drive omni mixer pipeline
//
// Usage: drive commands enter on cmd_i (opcode, drive_speed, heading, turn_rate) and
// leave as four wheel speeds on whl_o, one result beat for every command beat.
// Opcode rotate puts drive_speed on all four wheels; opcode move rotates the heading
// by 45 degrees, takes sine and cosine in two quarter-wave units and scales one
// wheel of each diagonal pair by the turn-rate factor.
// From an accepted command to its result on whl_o a command passes 2 front-end
// stages, 7 sine stages and 3 mixing stages; the last is the output register.
// Throughput is one command per cycle: a command can be taken every
// cycle while the output beat is consumed or the output register is empty.
// When the receiver holds ready low with a result waiting, the whole pipeline
// holds its contents and cmd_i.ready drops in the same cycle; nothing is lost
// or repeated, and flow resumes in the same cycle that ready returns.
// Reset clears every stage valid bit, so no result appears until a command
// has travelled the full pipeline; the data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module x_drive_omni_wheel_mixer_unit (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  xdm_cmd_if.sink     cmd_i,
  xdm_whl_if.source   whl_o
);
  import xdm_pkg::*;

  logic                          en;
  logic                          out_valid;
  logic                          prep_valid;
  logic [NUM_BITS-1:0]           num_a, num_b;
  side_t                         prep_side;
  logic [T_BITS-1:0]             sin_a, sin_b;
  logic                          vdly_q [SIN_LAT];
  side_t                         sdly_q [SIN_LAT];

  // whole pipeline advances unless a result waits on a stalled receiver
  assign en          = !out_valid || whl_o.ready;
  assign cmd_i.ready = en;

  xdm_angle_prep u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (cmd_i.valid),
    .op_i      (op_e'(cmd_i.opcode)),
    .speed_i   (cmd_i.drive_speed),
    .heading_i (cmd_i.heading),
    .rate_i    (cmd_i.turn_rate),
    .valid_o   (prep_valid),
    .num_a_o   (num_a),
    .num_b_o   (num_b),
    .side_o    (prep_side)
  );

  // quarter sine of the offset and of its complement
  xdm_sin_quarter u_sin_a (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num_a),
    .sin_o (sin_a)
  );

  xdm_sin_quarter u_sin_b (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num_b),
    .sin_o (sin_b)
  );

  // command data and valid delayed alongside the sine units
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SIN_LAT; i++) begin
        vdly_q[i] <= 1'b0;
      end
    end else if (en) begin
      vdly_q[0] <= prep_valid;
      for (int i = 1; i < SIN_LAT; i++) begin
        vdly_q[i] <= vdly_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sdly_q[0] <= prep_side;
      for (int i = 1; i < SIN_LAT; i++) begin
        sdly_q[i] <= sdly_q[i-1];
      end
    end
  end

  xdm_wheel_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vdly_q[SIN_LAT-1]),
    .side_i  (sdly_q[SIN_LAT-1]),
    .sa_i    (sin_a),
    .sb_i    (sin_b),
    .valid_o (out_valid),
    .fl_o    (whl_o.front_left_speed),
    .fr_o    (whl_o.front_right_speed),
    .bl_o    (whl_o.back_left_speed),
    .br_o    (whl_o.back_right_speed)
  );

  assign whl_o.valid = out_valid;

endmodule

`default_nettype wire

/* tb/x_drive_omni_wheel_mixer_unit_test.sv */
// testbench for the x-drive omni wheel mixer: random drive commands checked against a predictor
`timescale 1ns / 1ps

module x_drive_omni_wheel_mixer_unit_test;
  import xdm_pkg::*;

  localparam int  NUM_RANDOM  = 1350;
  localparam int  CYCLE_LIMIT = 200000;
  localparam int  DRAIN_WAIT  = 24;
  localparam int  IDLE_PCT    = 19;

  // sine polynomial coefficients, q30
  localparam longint K1 = 1686629713;
  localparam longint K3 = -693598243;
  localparam longint K5 = 85557789;
  localparam longint K7 = -4847435;

  typedef struct {
    op_e                          op;
    logic signed [SPEED_BITS-1:0] speed;
    logic [HEAD_BITS-1:0]         heading;
    logic signed [RATE_BITS-1:0]  rate;
  } drive_cmd_t;

  typedef struct {
    logic signed [SPEED_BITS-1:0] fl;
    logic signed [SPEED_BITS-1:0] fr;
    logic signed [SPEED_BITS-1:0] bl;
    logic signed [SPEED_BITS-1:0] br;
  } wheel_set_t;

  logic clk_i;
  logic rst_ni;

  xdm_cmd_if cmd_bus ();
  xdm_whl_if whl_bus ();

  x_drive_omni_wheel_mixer_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_bus),
    .whl_o  (whl_bus)
  );

  drive_cmd_t pending_cmds[$];
  wheel_set_t expected_wheels[$];
  int         errors = 0;
  int         cycles = 0;
  bit         cmd_taken = 1'b0;
  bit         steady;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // quarter-wave sine, x in 0..1440, q15
  function automatic longint quarter_sine(longint x);
    longint t, z, p;
    t = (x * 32768 + 720) / 1440;
    z = (t * t) >>> 15;
    p = K7;
    p = K5 + ((p * z) >>> 15);
    p = K3 + ((p * z) >>> 15);
    p = K1 + ((p * z) >>> 15);
    return (p * t + (longint'(1) << 29)) >>> 30;
  endfunction

  // full-turn sine, angle in sixteenths of a degree
  function automatic longint full_sine(longint ang);
    longint q, r;
    q = ang / 1440;
    r = ang % 1440;
    case (q)
      0: return quarter_sine(r);
      1: return quarter_sine(1440 - r);
      2: return -quarter_sine(r);
      default: return -quarter_sine(1440 - r);
    endcase
  endfunction

  // wheel speeds for one drive command
  function automatic wheel_set_t mix_wheels(drive_cmd_t c);
    wheel_set_t w;
    longint     spd, ang, rate, absr, m, d1, d2, d1r, d2r;
    bit         pos, fwd1, fwd2;
    spd = c.speed;
    if (spd < -32767) spd = -32767;
    if (c.op == OP_ROTATE) begin
      w.fl = 16'(spd);
      w.fr = 16'(spd);
      w.bl = 16'(spd);
      w.br = 16'(spd);
      return w;
    end
    ang  = (longint'(c.heading) + 720) % 5760;
    rate = c.rate;
    if (rate > 16384) rate = 16384;
    if (rate < -16384) rate = -16384;
    pos  = rate >= 0;
    absr = pos ? rate : -rate;
    m    = 16384 - 2 * absr;
    d1   = (spd * full_sine(ang) + (longint'(1) << 14)) >>> 15;
    d2   = (spd * full_sine((ang + 1440) % 5760) + (longint'(1) << 14)) >>> 15;
    d1r  = (d1 * m + (longint'(1) << 13)) >>> 14;
    d2r  = (d2 * m + (longint'(1) << 13)) >>> 14;
    fwd1 = ang <= 2880;
    fwd2 = !(ang >= 1440 && ang <= 4320);
    // reduced wheel of each diagonal pair follows half-plane and turn sign
    if (fwd1 == pos) begin
      w.fl = 16'(d1);
      w.br = 16'(d1r);
    end else begin
      w.fl = 16'(d1r);
      w.br = 16'(d1);
    end
    if (fwd2 == pos) begin
      w.fr = 16'(d2r);
      w.bl = 16'(d2);
    end else begin
      w.fr = 16'(d2);
      w.bl = 16'(d2r);
    end
    return w;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  task automatic add_cmd(op_e op, int speed, int heading, int rate);
    drive_cmd_t c;
    c.op      = op;
    c.speed   = 16'(speed);
    c.heading = 13'(heading);
    c.rate    = 16'(rate);
    pending_cmds.push_back(c);
  endtask

  // random command, mostly in range with some edge and out-of-range values
  function automatic drive_cmd_t random_cmd();
    drive_cmd_t c;
    int         pick;
    c.op = ($urandom_range(9) == 0) ? OP_ROTATE : OP_MOVE;
    pick = $urandom_range(99);
    if (pick < 3) c.speed = 16'sh8000;
    else if (pick < 6) c.speed = 16'sh7fff;
    else if (pick < 9) c.speed = 16'sh8001;
    else c.speed = 16'($urandom);
    if ($urandom_range(99) < 85) c.heading = 13'($urandom_range(5759));
    else c.heading = 13'($urandom);
    pick = $urandom_range(99);
    if (pick < 70) c.rate = 16'(int'($urandom_range(32768)) - 16384);
    else if (pick < 75) c.rate = 16'sd16384;
    else if (pick < 80) c.rate = -16'sd16384;
    else c.rate = 16'($urandom);
    return c;
  endfunction

  // stimulus, reset and end of run
  initial begin
    cmd_bus.valid       = 1'b0;
    cmd_bus.opcode      = OP_MOVE;
    cmd_bus.drive_speed = '0;
    cmd_bus.heading     = '0;
    cmd_bus.turn_rate   = '0;
    whl_bus.ready       = 1'b0;
    rst_ni              = 1'b0;

    // directed: speed extremes, both opcodes, quadrant edges, wrap and clamp cases
    add_cmd(OP_ROTATE, 32767, 100, 0);
    add_cmd(OP_ROTATE, -32768, 8191, -32768);
    add_cmd(OP_ROTATE, 0, 0, 32767);
    add_cmd(OP_ROTATE, -1, 5759, 16384);
    add_cmd(OP_MOVE, 32767, 0, 0);
    add_cmd(OP_MOVE, -32768, 0, 0);
    add_cmd(OP_MOVE, 32767, 720, 16384);
    add_cmd(OP_MOVE, 32767, 2160, -16384);
    add_cmd(OP_MOVE, 32767, 3600, 8000);
    add_cmd(OP_MOVE, -20000, 5759, -8000);
    add_cmd(OP_MOVE, 32767, 5760, 32767);
    add_cmd(OP_MOVE, 32767, 8191, -32768);
    add_cmd(OP_MOVE, 12345, 1000, 16385);
    add_cmd(OP_MOVE, -32767, 2161, -16385);
    add_cmd(OP_MOVE, 32767, 719, 0);
    add_cmd(OP_MOVE, 32767, 5040, -1);
    add_cmd(OP_MOVE, 100, 4000, 1);
    add_cmd(OP_MOVE, 0, 3000, 5000);
    add_cmd(OP_MOVE, -32768, 3601, 16384);
    add_cmd(OP_MOVE, 32767, 2159, -16384);
    for (int i = 0; i < NUM_RANDOM; i++) pending_cmds.push_back(random_cmd());

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_cmds.size() != 0 || cmd_bus.valid || expected_wheels.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (expected_wheels.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_wheels.size()));
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // cycle count, quiet window and timeout
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  assign steady = (cycles >= 1200) && (cycles < 2000);

  // command driver
  always @(negedge clk_i) begin
    drive_cmd_t c;
    if (rst_ni && (!cmd_bus.valid || cmd_taken)) begin
      if (pending_cmds.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        c = pending_cmds.pop_front();
        cmd_bus.opcode      <= c.op;
        cmd_bus.drive_speed <= c.speed;
        cmd_bus.heading     <= c.heading;
        cmd_bus.turn_rate   <= c.rate;
        cmd_bus.valid       <= 1'b1;
      end else begin
        cmd_bus.valid <= 1'b0;
      end
    end
  end

  // wheel receiver backpressure
  always @(negedge clk_i) begin
    if (rst_ni) whl_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // predict on each accepted command beat
  always @(posedge clk_i) begin
    drive_cmd_t c;
    cmd_taken = rst_ni && cmd_bus.valid && cmd_bus.ready;
    if (cmd_taken) begin
      c.op      = op_e'(cmd_bus.opcode);
      c.speed   = cmd_bus.drive_speed;
      c.heading = cmd_bus.heading;
      c.rate    = cmd_bus.turn_rate;
      expected_wheels.push_back(mix_wheels(c));
    end
  end

  // compare each wheel beat against the oldest prediction
  always @(posedge clk_i) begin
    wheel_set_t w;
    if (rst_ni && whl_bus.valid && whl_bus.ready) begin
      if (expected_wheels.size() == 0) begin
        report_mismatch("wheel beat with no command waiting");
      end else begin
        w = expected_wheels.pop_front();
        if (whl_bus.front_left_speed !== w.fl)
          report_mismatch($sformatf("front_left got %0d exp %0d",
                                    whl_bus.front_left_speed, w.fl));
        if (whl_bus.front_right_speed !== w.fr)
          report_mismatch($sformatf("front_right got %0d exp %0d",
                                    whl_bus.front_right_speed, w.fr));
        if (whl_bus.back_left_speed !== w.bl)
          report_mismatch($sformatf("back_left got %0d exp %0d",
                                    whl_bus.back_left_speed, w.bl));
        if (whl_bus.back_right_speed !== w.br)
          report_mismatch($sformatf("back_right got %0d exp %0d",
                                    whl_bus.back_right_speed, w.br));
      end
    end
  end

endmodule
